// ----- rtl/core/pid_pkg.sv -----
// Shared types and constants for the positional PID controller.
// Depends on nothing; used by every module under rtl/core.
package pid_pkg;

  // Fixed field widths
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 16;
  localparam int OLIMIT_W   = 15;
  localparam int DRIVE_W    = 16;
  localparam int INTEG_W    = 17;  // |integral| <= 65534 after clamping
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_P       = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_I       = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D       = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SEP_THRESH   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_INTEG_LIMIT  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_LIMIT = 3'd5;

  // Reset values
  localparam logic [LIMIT_W-1:0]  SEP_THRESH_RST   = 16'd65;
  localparam logic [LIMIT_W-1:0]  INTEG_LIMIT_RST  = 16'd500;
  localparam logic [OLIMIT_W-1:0] OUTPUT_LIMIT_RST = 15'd1000;

  // Configuration seen by the datapath
  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic [LIMIT_W-1:0]       sep_thresh;
    logic [LIMIT_W-1:0]       integ_limit;
    logic [OLIMIT_W-1:0]      output_limit;
  } pid_cfg_t;

endpackage

// ----- rtl/core/pid_err_stage.sv -----
// Error stage: error, derivative, integral separation and integral clamp.
// Holds the controller state (integral and last error). Uses pid_pkg.
module pid_err_stage #(
  parameter int DATA_WIDTH = 16,
  localparam int EW = DATA_WIDTH + 1,
  localparam int IW = pid_pkg::INTEG_W
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pid_pkg::pid_cfg_t            cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] meas,
  input  logic signed [DATA_WIDTH-1:0] targ,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [EW-1:0]         err,
  output logic signed [EW:0]           derr,
  output logic signed [IW-1:0]         integ,
  output logic                         use_integ
);

  localparam int SW = ((EW > IW) ? EW : IW) + 1;
  localparam int MW = (EW > pid_pkg::LIMIT_W) ? EW : pid_pkg::LIMIT_W;

  // State
  logic signed [IW-1:0] integ_sum;
  logic signed [EW-1:0] prev_err;

  logic signed [EW-1:0] e_c;
  logic signed [EW:0]   de_c;
  logic [EW-1:0]        e_mag;
  logic                 use_c;
  logic signed [SW-1:0] sum;
  logic [SW-1:0]        sum_mag;
  logic [pid_pkg::LIMIT_W-1:0] ilim;
  logic signed [IW-1:0] integ_next;
  logic                 fire;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  // Error, derivative and separation test
  always_comb begin
    e_c   = EW'(targ) - EW'(meas);
    de_c  = (EW+1)'(e_c) - (EW+1)'(prev_err);
    e_mag = e_c[EW-1] ? EW'(-e_c) : EW'(e_c);
    use_c = MW'(e_mag) < MW'(cfg.sep_thresh);
  end

  // Integrate and clamp to +/-(limit-1); zero limit acts as one
  always_comb begin
    ilim    = (cfg.integ_limit == '0) ? pid_pkg::LIMIT_W'(1) : cfg.integ_limit;
    sum     = SW'(integ_sum) + (use_c ? SW'(e_c) : SW'(0));
    sum_mag = sum[SW-1] ? SW'(-sum) : SW'(sum);
    if (sum_mag >= SW'(ilim)) begin
      integ_next = sum[SW-1] ? -IW'(ilim - 1'b1) : IW'(ilim - 1'b1);
    end else begin
      integ_next = IW'(sum);
    end
  end

  // State update on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      integ_sum <= '0;
      prev_err  <= '0;
    end else if (fire) begin
      integ_sum <= integ_next;
      prev_err  <= e_c;
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      err       <= e_c;
      derr      <= de_c;
      integ     <= integ_next;
      use_integ <= use_c;
    end
  end

endmodule

// ----- rtl/core/pid_mac.sv -----
// Gain stage: three products, registered, then their sum, registered.
// Uses pid_pkg for the gain width and the configuration struct.
module pid_mac #(
  parameter int DATA_WIDTH = 16,
  localparam int EW = DATA_WIDTH + 1,
  localparam int IW = pid_pkg::INTEG_W,
  localparam int GW = pid_pkg::GAIN_W,
  localparam int PPW = GW + EW,
  localparam int PDW = GW + EW + 1,
  localparam int PIW = GW + IW,
  localparam int ACCW = ((PDW > PIW) ? PDW : PIW) + 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  pid_pkg::pid_cfg_t      cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [EW-1:0]   err,
  input  logic signed [EW:0]     derr,
  input  logic signed [IW-1:0]   integ,
  input  logic                   use_integ,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [ACCW-1:0] acc
);

  logic                  prod_valid;
  logic                  prod_ready;
  logic signed [PPW-1:0] prod_p;
  logic signed [PDW-1:0] prod_d;
  logic signed [PIW-1:0] prod_i;
  logic signed [IW-1:0]  integ_g;

  assign prod_ready = !out_valid || out_ready;
  assign in_ready   = !prod_valid || prod_ready;

  // Integral term drops out while integration is suspended
  assign integ_g = use_integ ? integ : '0;

  // Product register
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (in_ready) begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prod_p <= PPW'(cfg.gain_p) * PPW'(err);
      prod_d <= PDW'(cfg.gain_d) * PDW'(derr);
      prod_i <= PIW'(cfg.gain_i) * PIW'(integ_g);
    end
  end

  // Sum register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (prod_ready) begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_valid && prod_ready) begin
      acc <= ACCW'(prod_p) + ACCW'(prod_d) + ACCW'(prod_i);
    end
  end

endmodule

// ----- rtl/core/pid_limit.sv -----
// Output stage: fractional truncation toward zero and output clamp,
// into the result register. Uses pid_pkg.
module pid_limit #(
  parameter int ACCW = 37,
  parameter int GAIN_FRAC_BITS = 8,
  localparam int DW = pid_pkg::DRIVE_W
) (
  input  logic                   clk,
  input  logic                   rst,
  input  pid_pkg::pid_cfg_t      cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [ACCW-1:0] acc,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [DW-1:0]   drive,
  output logic                   clamped
);

  localparam logic [ACCW-1:0] Bias = ACCW'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

  logic signed [ACCW-1:0] biased;
  logic signed [ACCW-1:0] scaled;
  logic signed [ACCW-1:0] olim_s;
  logic [pid_pkg::OLIMIT_W-1:0] olim;
  logic [pid_pkg::OLIMIT_W-1:0] olim_m1;
  logic signed [DW-1:0]   drive_c;
  logic                   clamp_c;

  assign in_ready = !out_valid || out_ready;

  // Divide by 2^frac, truncating toward zero, then clamp to +/-(limit-1)
  always_comb begin
    biased  = acc + (acc[ACCW-1] ? $signed(Bias) : $signed(ACCW'(0)));
    scaled  = biased >>> GAIN_FRAC_BITS;
    olim    = (cfg.output_limit == '0) ? pid_pkg::OLIMIT_W'(1) : cfg.output_limit;
    olim_m1 = olim - 1'b1;
    olim_s  = $signed(ACCW'(olim));
    clamp_c = (scaled >= olim_s) || (scaled <= -olim_s);
    if (clamp_c) begin
      drive_c = scaled[ACCW-1] ? -DW'(olim_m1) : DW'(olim_m1);
    end else begin
      drive_c = scaled[DW-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      drive   <= drive_c;
      clamped <= clamp_c;
    end
  end

endmodule

// ----- rtl/core/positional_pid_controller.sv -----
// Positional PID controller with integral separation, top level.
// Depends on pid_pkg, pid_err_stage, pid_mac and pid_limit.
//
// One sample per transfer on s_axis, one result per sample on m_axis, in
// order. The block accepts a sample every cycle unless a stall at m_axis
// backs up to the input. A sample passes five registers: input register,
// error and integral stage, product register, sum register, result
// register. m_axis_tvalid rises when the sample reaches the result
// register. Each stage has its own valid bit and advances whenever the
// stage after it is empty or moving, so bubbles are squeezed out while
// the output is stalled.
// The integral and the last error update at the error stage, so back to
// back samples see each other's state. Write configuration only while the
// pipeline is empty; writes to unused indexes are dropped.
module positional_pid_controller #(
  parameter int DATA_WIDTH     = 16,
  parameter int GAIN_FRAC_BITS = 8,
  localparam int InTdataW = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [InTdataW-1:0]               s_axis_tdata,  // measured_value, target_value
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [pid_pkg::DRIVE_W-1:0]       m_axis_tdata,  // drive_value
  output logic [0:0]                        m_axis_tuser,  // output_clamped
  input  logic                              cfg_we,
  input  logic [pid_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [pid_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int EW   = DATA_WIDTH + 1;
  localparam int IW   = pid_pkg::INTEG_W;
  localparam int GW   = pid_pkg::GAIN_W;
  localparam int PDW  = GW + EW + 1;
  localparam int PIW  = GW + IW;
  localparam int ACCW = ((PDW > PIW) ? PDW : PIW) + 2;

  pid_pkg::pid_cfg_t cfg;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p       <= '0;
      cfg.gain_i       <= '0;
      cfg.gain_d       <= '0;
      cfg.sep_thresh   <= pid_pkg::SEP_THRESH_RST;
      cfg.integ_limit  <= pid_pkg::INTEG_LIMIT_RST;
      cfg.output_limit <= pid_pkg::OUTPUT_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pid_pkg::REG_GAIN_P:       cfg.gain_p       <= $signed(cfg_wdata);
        pid_pkg::REG_GAIN_I:       cfg.gain_i       <= $signed(cfg_wdata);
        pid_pkg::REG_GAIN_D:       cfg.gain_d       <= $signed(cfg_wdata);
        pid_pkg::REG_SEP_THRESH:   cfg.sep_thresh   <= cfg_wdata;
        pid_pkg::REG_INTEG_LIMIT:  cfg.integ_limit  <= cfg_wdata;
        pid_pkg::REG_OUTPUT_LIMIT: cfg.output_limit <= cfg_wdata[pid_pkg::OLIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic                         in_valid;
  logic                         in_ready;
  logic signed [DATA_WIDTH-1:0] meas;
  logic signed [DATA_WIDTH-1:0] targ;
  logic                         err_ready;

  assign in_ready      = !in_valid || err_ready;
  assign s_axis_tready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && in_ready) begin
      meas <= $signed(s_axis_tdata[DATA_WIDTH-1:0]);
      targ <= $signed(s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
    end
  end

  // Error stage
  logic                 err_valid;
  logic                 mac_ready;
  logic signed [EW-1:0] err;
  logic signed [EW:0]   derr;
  logic signed [IW-1:0] integ;
  logic                 use_integ;

  pid_err_stage #(.DATA_WIDTH(DATA_WIDTH)) u_err (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (err_ready),
    .meas      (meas),
    .targ      (targ),
    .out_valid (err_valid),
    .out_ready (mac_ready),
    .err       (err),
    .derr      (derr),
    .integ     (integ),
    .use_integ (use_integ)
  );

  // Gain stages
  logic                   acc_valid;
  logic                   lim_ready;
  logic signed [ACCW-1:0] acc;

  pid_mac #(.DATA_WIDTH(DATA_WIDTH)) u_mac (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (err_valid),
    .in_ready  (mac_ready),
    .err       (err),
    .derr      (derr),
    .integ     (integ),
    .use_integ (use_integ),
    .out_valid (acc_valid),
    .out_ready (lim_ready),
    .acc       (acc)
  );

  // Output stage
  logic signed [pid_pkg::DRIVE_W-1:0] drive;
  logic                               clamped;

  pid_limit #(.ACCW(ACCW), .GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_lim (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (acc_valid),
    .in_ready  (lim_ready),
    .acc       (acc),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .drive     (drive),
    .clamped   (clamped)
  );

  assign m_axis_tdata = drive;
  assign m_axis_tuser = clamped;

endmodule

// ----- rtl/core/pid_checker.sv -----
// Port-level checks for the positional PID controller, bound to the top.
// Depends on pid_pkg for port widths.
module pid_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [pid_pkg::DRIVE_W-1:0]    m_axis_tdata,
  input logic [0:0]                     m_axis_tuser
);

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Drive never reaches the full 16-bit extremes
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata != 16'h8000 && m_axis_tdata != 16'h7FFF)
    else $error("drive outside clamp range");

  // With no result pending, the pipeline is free to take a sample
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // A sample accepted while no result is pending and the output is ready yields a result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid && m_axis_tready && s_axis_tvalid && s_axis_tready |=>
      ##4 m_axis_tvalid)
    else $error("result missing after accepted sample");

endmodule

bind positional_pid_controller pid_checker u_pid_checker (.*);
